// File: src/tss_pkg.sv
`default_nettype none

package tss_pkg;

    // Score memory geometry.
    localparam int SCORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(SCORE_DEPTH);
    localparam int BYTE_W      = 8;

    // Note-to-period arithmetic.
    localparam int FREQ_W    = 12;
    localparam int NUMER_W   = 18;
    localparam int PERIOD_W  = 11;
    localparam int WAIT_W    = 9;
    localparam int DIV_STEPS = NUMER_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [BYTE_W-1:0]  CMD_STOP   = 8'hFF;
    localparam logic [FREQ_W-1:0]  FREQ_BASE  = 12'd220;
    localparam logic [NUMER_W-1:0] DIVIDEND   = 18'd131072;
    localparam logic [FREQ_W-1:0]  PERIOD_TOP = 12'd2048;

    // Stream word widths.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_CMD,
        ST_CHECK_CMD,
        ST_GET_NOTE,
        ST_GET_DUR,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mem_wr;
        logic start;
        logic clear_play;
        logic wait_dec;
        logic rd_byte;
        logic latch_note;
        logic set_wait;
        logic stage_silence;
        logic stage_tone;
        logic div_start;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic playing;
        logic wait_zero;
        logic byte_is_stop;
        logic byte_zero;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/tone_score_sequencer_core.sv
// Load, start and ticks that only count down are handled in the idle state; a stop
// goes to the emit state, which registers its silence word. A tick that plays a note
// steps through accept, 3 score reads, divider load, 18 divider steps (one quotient bit
// a cycle) and emit; end-of-score emits a silence word, a zero-length note none.
// Emit waits while the previous result word is held. Synchronous reset (aresetn low)
// clears position, wait count, playing flag and output valid; score memory is kept.
`default_nettype none

module tone_score_sequencer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tss_pkg::S_DATA_W-1:0]   s_tdata,  // load_address[9:0], load_byte[17:10]
    input  wire logic [1:0]                     s_tuser,  // mode[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tss_pkg::M_DATA_W-1:0]        m_tdata,  // tone_period[10:0], tone_length[18:11], is_playing[19]
    output logic                                m_tuser   // tone_on[0]
);
    import tss_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    state_t              state;
    mode_t               mode;
    logic                tone_on;
    logic [PERIOD_W-1:0] tone_period;
    logic [BYTE_W-1:0]   tone_length;
    logic                is_playing;

    assign mode = mode_t'(s_tuser);

    tss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (mode),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd),
        .state    (state)
    );

    tss_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .load_address (s_tdata[ADDR_W-1:0]),
        .load_byte    (s_tdata[ADDR_W +: BYTE_W]),
        .m_tready     (m_tready),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .tone_on      (tone_on),
        .tone_period  (tone_period),
        .tone_length  (tone_length),
        .is_playing   (is_playing)
    );

    assign m_tdata = {
        (M_DATA_W - PERIOD_W - BYTE_W - 1)'(0), is_playing, tone_length, tone_period
    };
    assign m_tuser = tone_on;

    // A tone word always reports playback as active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[PERIOD_W + BYTE_W])
        else $error("tone word without playing flag");

    // A silence word carries zero period and length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[PERIOD_W + BYTE_W - 1:0] == '0))
        else $error("silence word with nonzero payload");

    // Zero-duration notes never produce a tone word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[PERIOD_W +: BYTE_W] != '0))
        else $error("tone word with zero length");

    // A taken start word leaves the block playing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (mode == MODE_START) |=> stat.playing)
        else $error("start word did not set playing");

    // A finished divider in the divider state always leads to the emit state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_DIVIDE) && stat.div_last |=> (state == ST_EMIT))
        else $error("divider finished without emitting");

endmodule

`default_nettype wire

// File: src/tss_ctrl.sv
`default_nettype none

module tss_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire tss_pkg::mode_t    mode,
    input  wire tss_pkg::dp_stat_t stat,
    output logic                   s_tready,
    output tss_pkg::dp_cmd_t       cmd,
    output tss_pkg::state_t        state
);
    import tss_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign state    = state_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (mode == MODE_STOP) begin
                        state_next = ST_EMIT;
                    end else if (mode == MODE_TICK && stat.playing && stat.wait_zero) begin
                        state_next = ST_FETCH_CMD;
                    end
                end
            end
            ST_FETCH_CMD: state_next = ST_CHECK_CMD;
            ST_CHECK_CMD: begin
                state_next = stat.byte_is_stop ? ST_EMIT : ST_GET_NOTE;
            end
            ST_GET_NOTE:  state_next = ST_GET_DUR;
            ST_GET_DUR: begin
                state_next = stat.byte_zero ? ST_IDLE : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (stat.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.mem_wr = (mode == MODE_LOAD);
                    cmd.start  = (mode == MODE_START);
                    if (mode == MODE_STOP) begin
                        cmd.clear_play    = 1'b1;
                        cmd.stage_silence = 1'b1;
                    end
                    cmd.wait_dec = (mode == MODE_TICK) && stat.playing && !stat.wait_zero;
                end
            end
            ST_FETCH_CMD: cmd.rd_byte = 1'b1;
            ST_CHECK_CMD: begin
                if (stat.byte_is_stop) begin
                    cmd.clear_play    = 1'b1;
                    cmd.stage_silence = 1'b1;
                end else begin
                    cmd.rd_byte = 1'b1;
                end
            end
            ST_GET_NOTE: begin
                cmd.latch_note = 1'b1;
                cmd.rd_byte    = 1'b1;
            end
            ST_GET_DUR: begin
                cmd.set_wait = 1'b1;
                if (!stat.byte_zero) begin
                    cmd.stage_tone = 1'b1;
                    cmd.div_start  = 1'b1;
                end
            end
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_EMIT:   cmd.emit = stat.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/tss_datapath.sv
`default_nettype none

module tss_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tss_pkg::dp_cmd_t               cmd,
    input  wire logic [tss_pkg::ADDR_W-1:0]     load_address,
    input  wire logic [tss_pkg::BYTE_W-1:0]     load_byte,
    input  wire logic                           m_tready,
    output tss_pkg::dp_stat_t                   stat,
    output logic                                m_tvalid,
    output logic                                tone_on,
    output logic [tss_pkg::PERIOD_W-1:0]        tone_period,
    output logic [tss_pkg::BYTE_W-1:0]          tone_length,
    output logic                                is_playing
);
    import tss_pkg::*;

    // Score memory with one write and one registered read port.
    logic [BYTE_W-1:0] score_mem [SCORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic                 playing_reg, playing_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 m_valid_reg, m_valid_next;

    logic [FREQ_W-1:0]  freq_reg;
    logic [FREQ_W-1:0]  rem_reg;
    logic [NUMER_W-1:0] dq_reg;
    logic               res_on_reg;
    logic [BYTE_W-1:0]  res_len_reg;

    logic                m_on_reg;
    logic [PERIOD_W-1:0] m_period_reg;
    logic [BYTE_W-1:0]   m_len_reg;
    logic                m_play_reg;

    logic [FREQ_W:0]     trial;
    logic [FREQ_W:0]     trial_sub;
    logic                trial_ge;
    logic [FREQ_W-1:0]   period_diff;
    logic [PERIOD_W-1:0] period;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            score_mem[load_address] <= load_byte;
        end
        if (cmd.rd_byte) begin
            rdata_reg <= score_mem[pos_reg];
        end
    end

    // Read position, wait count and playing flag.
    always_comb begin
        pos_next     = pos_reg;
        wait_next    = wait_reg;
        playing_next = playing_reg;
        if (cmd.start) begin
            pos_next     = '0;
            wait_next    = '0;
            playing_next = 1'b1;
        end
        if (cmd.rd_byte) begin
            pos_next = pos_reg + ADDR_W'(1);
        end
        if (cmd.wait_dec) begin
            wait_next = wait_reg - WAIT_W'(1);
        end
        if (cmd.set_wait) begin
            wait_next = {rdata_reg, 1'b0};
        end
        if (cmd.clear_play) begin
            playing_next = 1'b0;
        end
    end

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    assign trial     = {rem_reg, dq_reg[NUMER_W-1]};
    assign trial_sub = trial - {1'b0, freq_reg};
    assign trial_ge  = (trial >= {1'b0, freq_reg});

    always_comb begin
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start) begin
            div_cnt_next = '0;
        end else if (cmd.div_step) begin
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Period from the quotient, zero when the quotient reaches the top.
    assign period_diff = PERIOD_TOP - dq_reg[FREQ_W-1:0];
    assign period      = (|dq_reg[NUMER_W-1:PERIOD_W]) ? '0 : period_diff[PERIOD_W-1:0];

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            wait_reg    <= '0;
            playing_reg <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            wait_reg    <= wait_next;
            playing_reg <= playing_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch_note) begin
            freq_reg <= FREQ_BASE + {1'b0, rdata_reg, 3'b000};
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            dq_reg  <= DIVIDEND;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
            dq_reg  <= {dq_reg[NUMER_W-2:0], trial_ge};
        end
        if (cmd.stage_silence) begin
            res_on_reg  <= 1'b0;
            res_len_reg <= '0;
        end else if (cmd.stage_tone) begin
            res_on_reg  <= 1'b1;
            res_len_reg <= rdata_reg;
        end
        if (cmd.emit) begin
            m_on_reg     <= res_on_reg;
            m_period_reg <= res_on_reg ? period : '0;
            m_len_reg    <= res_len_reg;
            m_play_reg   <= playing_reg;
        end
    end

    assign stat.playing      = playing_reg;
    assign stat.wait_zero    = (wait_reg == '0);
    assign stat.byte_is_stop = (rdata_reg == CMD_STOP);
    assign stat.byte_zero    = (rdata_reg == '0);
    assign stat.div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid    = m_valid_reg;
    assign tone_on     = m_on_reg;
    assign tone_period = m_period_reg;
    assign tone_length = m_len_reg;
    assign is_playing  = m_play_reg;

endmodule

`default_nettype wire
